FILE: sv/swtd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sample window trend detector.
// No dependencies.
package swtd_pkg;

	localparam int PRESSURE_W = 14;
	localparam int TIME_W     = 32;
	localparam int THRESH_W   = 10;
	localparam int SLOT_W     = 4;
	localparam int REG_IDX_W  = 2;
	localparam int REG_DATA_W = 32;

	localparam logic [SLOT_W-1:0]   SLOT_PERIOD    = 4'd12;
	localparam logic [SLOT_W-1:0]   SLOT_FIRST     = 4'd1;
	localparam logic [TIME_W-1:0]   INTERVAL_RESET = 32'd3600000;
	localparam logic [THRESH_W-1:0] THRESH_RESET   = 10'd10;

	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TREND_THRESHOLD = 2'd1;

	typedef enum logic [1:0] {
		TREND_STEADY  = 2'd0,
		TREND_RISING  = 2'd1,
		TREND_FALLING = 2'd2
	} trend_t;

endpackage

FILE: sv/swtd_trend_cmp.sv
`timescale 1ns / 1ps
// Trend decision: newest minus oldest sample against a symmetric threshold.
// Depends on swtd_pkg.
module swtd_trend_cmp (
	input  logic                           enough,
	input  logic [swtd_pkg::PRESSURE_W-1:0] newest,
	input  logic [swtd_pkg::PRESSURE_W-1:0] oldest,
	input  logic [swtd_pkg::THRESH_W-1:0]   threshold,
	output swtd_pkg::trend_t               trend
);

	logic [swtd_pkg::PRESSURE_W:0]   diff_up;
	logic [swtd_pkg::PRESSURE_W:0]   diff_dn;
	logic [swtd_pkg::PRESSURE_W-1:0] thr_ext;
	logic                            rise;
	logic                            fall;

	always_comb begin
		diff_up = {1'b0, newest} - {1'b0, oldest};
		diff_dn = {1'b0, oldest} - {1'b0, newest};
		thr_ext = swtd_pkg::PRESSURE_W'(threshold);
		rise = !diff_up[swtd_pkg::PRESSURE_W] &&
			(diff_up[swtd_pkg::PRESSURE_W-1:0] > thr_ext);
		fall = !diff_dn[swtd_pkg::PRESSURE_W] &&
			(diff_dn[swtd_pkg::PRESSURE_W-1:0] > thr_ext);
		if (!enough) begin
			trend = swtd_pkg::TREND_STEADY;
		end else if (rise) begin
			trend = swtd_pkg::TREND_RISING;
		end else if (fall) begin
			trend = swtd_pkg::TREND_FALLING;
		end else begin
			trend = swtd_pkg::TREND_STEADY;
		end
	end

endmodule

FILE: sv/sample_window_trend_detector.sv
`timescale 1ns / 1ps
// The result passes through two register stages, ring read and output, before it
// reaches the output; a stall on out_ready can hold it in the ring read stage.
// Throughput: one transaction per cycle unless out_ready stalls the output; the ring
// memory takes one write and one read per cycle; oldest is read as newest is written.
// Reset: asynchronous, active low; clears pointers, fill, slot, timers, registers
// and valid flags. Ring contents are not cleared; trends use only written entries.
// Depends on swtd_pkg and swtd_trend_cmp.
module sample_window_trend_detector #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [swtd_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [swtd_pkg::REG_DATA_W-1:0]      wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 sample_valid,
	input  logic [swtd_pkg::PRESSURE_W-1:0]      pressure,
	input  logic [swtd_pkg::TIME_W-1:0]          now_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 stored,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0]    sample_count,
	output logic [1:0]                           trend,
	output logic [swtd_pkg::SLOT_W-1:0]          period_slot
);

	localparam int PW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);

	logic [swtd_pkg::PRESSURE_W-1:0] ring_mem [WINDOW_DEPTH];

	logic [swtd_pkg::TIME_W-1:0]   interval_q;
	logic [swtd_pkg::THRESH_W-1:0] threshold_q;
	logic [PW-1:0]                 head_q;
	logic [PW-1:0]                 tail_q;
	logic [FW-1:0]                 fill_q;
	logic [swtd_pkg::TIME_W-1:0]   last_time_q;
	logic [swtd_pkg::SLOT_W-1:0]   slot_q;
	logic [swtd_pkg::PRESSURE_W-1:0] newest_q;
	logic [swtd_pkg::PRESSURE_W-1:0] rd_data_q;

	logic                            s1_valid_q;
	logic                            stored_s1;
	logic [FW-1:0]                   fill_s1;
	logic [swtd_pkg::SLOT_W-1:0]     slot_s1;
	logic [swtd_pkg::PRESSURE_W-1:0] newest_s1;

	logic                          out_valid_q;
	logic                          out_stored_q;
	logic [FW-1:0]                 out_fill_q;
	swtd_pkg::trend_t              out_trend_q;
	logic [swtd_pkg::SLOT_W-1:0]   out_slot_q;

	logic                          in_fire;
	logic                          s1_adv;
	logic                          push;
	logic                          full;
	logic [swtd_pkg::TIME_W-1:0]   elapsed;
	logic [PW-1:0]                 head_inc;
	logic [PW-1:0]                 tail_inc;
	logic [PW-1:0]                 tail_next;
	logic [FW-1:0]                 fill_next;
	logic [swtd_pkg::SLOT_W-1:0]   slot_next;
	swtd_pkg::trend_t              trend_s1;

	always_comb begin
		s1_adv   = !out_valid_q || out_ready;
		in_ready = !s1_valid_q || s1_adv;
		in_fire  = in_valid && in_ready;
		full     = (fill_q == FW'(WINDOW_DEPTH));
		elapsed  = now_ms - last_time_q;
		push     = in_fire && sample_valid &&
			((fill_q == '0) || (elapsed >= interval_q));
		head_inc = (head_q == PW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_inc = (tail_q == PW'(WINDOW_DEPTH - 1)) ? '0 : tail_q + 1'b1;
		tail_next = (push && full) ? tail_inc : tail_q;
		fill_next = (push && !full) ? fill_q + 1'b1 : fill_q;
		if (push && (fill_q != '0)) begin
			slot_next = (slot_q >= swtd_pkg::SLOT_PERIOD) ?
				swtd_pkg::SLOT_FIRST : slot_q + 1'b1;
		end else begin
			slot_next = slot_q;
		end
	end

	// ring: write newest at head, read the oldest of the updated window
	always_ff @(posedge clk) begin
		if (push) begin
			ring_mem[head_q] <= pressure;
		end
		if (in_fire) begin
			rd_data_q <= ring_mem[tail_next];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= swtd_pkg::INTERVAL_RESET;
			threshold_q <= swtd_pkg::THRESH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				swtd_pkg::REG_SAMPLE_INTERVAL: interval_q <= wr_data;
				swtd_pkg::REG_TREND_THRESHOLD:
					threshold_q <= wr_data[swtd_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			last_time_q <= '0;
			slot_q      <= swtd_pkg::SLOT_FIRST;
		end else if (push) begin
			head_q      <= head_inc;
			tail_q      <= tail_next;
			fill_q      <= fill_next;
			last_time_q <= now_ms;
			slot_q      <= slot_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			newest_q <= pressure;
		end
		if (in_fire) begin
			stored_s1 <= push;
			fill_s1   <= fill_next;
			slot_s1   <= slot_next;
			newest_s1 <= push ? pressure : newest_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_fire;
		end
	end

	swtd_trend_cmp u_cmp (
		.enough    (fill_s1 >= FW'(2)),
		.newest    (newest_s1),
		.oldest    (rd_data_q),
		.threshold (threshold_q),
		.trend     (trend_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_q) begin
			out_stored_q <= stored_s1;
			out_fill_q   <= fill_s1;
			out_trend_q  <= trend_s1;
			out_slot_q   <= slot_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign stored       = out_stored_q;
	assign sample_count = out_fill_q;
	assign trend        = out_trend_q;
	assign period_slot  = out_slot_q;

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_DEPTH))
		else $error("window fill above depth");

	a_ring_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == FW'(WINDOW_DEPTH)) |-> head_q == tail_q)
		else $error("ring head and tail disagree with fill");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q >= swtd_pkg::SLOT_FIRST && slot_q <= swtd_pkg::SLOT_PERIOD)
		else $error("period slot out of range");

	a_trend_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_trend_q != swtd_pkg::TREND_STEADY) |-> out_fill_q >= FW'(2))
		else $error("trend reported with fewer than two samples");
`endif

endmodule
